>>> rtl/bsc_pkg.sv
// Shared constants and types for the box / sphere collision test.
`default_nettype none

package bsc_pkg;

    // Default width of one coordinate lane (signed Q8.8 positions, unsigned sizes).
    localparam int COORD_BITS_DEF = 16;

    // Width of one packed three-lane field on the ports.
    localparam int FIELD_W = 48;

    // Body shape codes.
    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_SPHERE = 1'b1;

    // Load enables of the pipeline stages behind the input register.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } bsc_en_t;

endpackage

`default_nettype wire

>>> rtl/box_sphere_collision_test.sv
// Box / sphere collision test: three axis lanes in parallel, then a merge stage.
// Path from input acceptance to out_valid: input register, four lane stages,
// merge sum, output register. Throughput: one item per cycle while out_ready is
// high, set by the fully pipelined lanes, each with one multiplier, and merge.
// Reset: rst_n clears only the stage valid bits; datapath registers are not reset.
`default_nettype none

module box_sphere_collision_test #(
    parameter int COORD_BITS = bsc_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         kind_a,
    input  wire logic [bsc_pkg::FIELD_W-1:0]  pos_a,
    input  wire logic [bsc_pkg::FIELD_W-1:0]  ext_a,
    input  wire logic                         kind_b,
    input  wire logic [bsc_pkg::FIELD_W-1:0]  pos_b,
    input  wire logic [bsc_pkg::FIELD_W-1:0]  ext_b,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              collide
);

    localparam int C      = COORD_BITS;
    localparam int LANE_W = 3 * C;
    localparam int FW     = bsc_pkg::FIELD_W;
    localparam int NST    = 7;   // input register plus six stages

    // Pipeline control. Each stage loads when it is empty or the stage after it
    // loads, so bubbles collapse and a stalled output only blocks what is behind it.
    logic [NST-1:0] valid_reg;
    logic [NST:0]   adv;

    always_comb
    begin
        adv[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (adv[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NST-1];

    bsc_pkg::bsc_en_t en;

    assign en.s1 = adv[1];
    assign en.s2 = adv[2];
    assign en.s3 = adv[3];
    assign en.s4 = adv[4];
    assign en.s5 = adv[5];
    assign en.s6 = adv[6];

    // Input register. Lanes that run past the 48-bit field read as zero.
    logic [LANE_W+FW-1:0] pos_a_wide, ext_a_wide, pos_b_wide, ext_b_wide;

    assign pos_a_wide = {{LANE_W{1'b0}}, pos_a};
    assign ext_a_wide = {{LANE_W{1'b0}}, ext_a};
    assign pos_b_wide = {{LANE_W{1'b0}}, pos_b};
    assign ext_b_wide = {{LANE_W{1'b0}}, ext_b};

    logic              kind_a_reg, kind_b_reg;
    logic [LANE_W-1:0] pos_a_reg, ext_a_reg, pos_b_reg, ext_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            kind_a_reg <= kind_a;
            kind_b_reg <= kind_b;
            pos_a_reg  <= pos_a_wide[LANE_W-1:0];
            ext_a_reg  <= ext_a_wide[LANE_W-1:0];
            pos_b_reg  <= pos_b_wide[LANE_W-1:0];
            ext_b_reg  <= ext_b_wide[LANE_W-1:0];
        end
    end

    // Sphere radii always sit in the x lane of the extent field.
    logic [C-1:0] ra, rb;

    assign ra = ext_a_reg[C-1:0];
    assign rb = ext_b_reg[C-1:0];

    // One lane per axis: x, y, z.
    logic [2:0][2*C+7:0] lane_sq;
    logic [2:0]          lane_ovl;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        bsc_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (en),
            .kind_a (kind_a_reg),
            .kind_b (kind_b_reg),
            .pa     (pos_a_reg[i*C +: C]),
            .sa     (ext_a_reg[i*C +: C]),
            .pb     (pos_b_reg[i*C +: C]),
            .sb     (ext_b_reg[i*C +: C]),
            .ra     (ra),
            .rb     (rb),
            .sq     (lane_sq[i]),
            .ovl    (lane_ovl[i])
        );
    end

    // Combine the lanes: box-box takes the AND of the overlap bits, every case
    // with a sphere compares the squared distance against the squared threshold.
    bsc_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .clk     (clk),
        .en      (en),
        .kind_a  (kind_a_reg),
        .kind_b  (kind_b_reg),
        .ra      (ra),
        .rb      (rb),
        .sq      (lane_sq),
        .ovl     (lane_ovl),
        .collide (collide)
    );

endmodule

`default_nettype wire

>>> rtl/bsc_lane.sv
// One axis lane: interval overlap, clamped center offset, its clamp error and the square of that error.
`default_nettype none

module bsc_lane #(
    parameter int COORD_BITS = bsc_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire bsc_pkg::bsc_en_t          en,
    input  wire logic                      kind_a,
    input  wire logic                      kind_b,
    input  wire logic [COORD_BITS-1:0]     pa,
    input  wire logic [COORD_BITS-1:0]     sa,
    input  wire logic [COORD_BITS-1:0]     pb,
    input  wire logic [COORD_BITS-1:0]     sb,
    input  wire logic [COORD_BITS-1:0]     ra,
    input  wire logic [COORD_BITS-1:0]     rb,
    output logic      [2*COORD_BITS+7:0]   sq,
    output logic                           ovl
);

    localparam int C    = COORD_BITS;
    localparam int CW   = C + 3;       // doubled centers
    localparam int DW   = C + 4;       // center difference and clamp error
    localparam int SQW  = 2 * C + 8;

    // Stage 1: overlap bit, doubled centers, clamp half extent
    logic signed [C+1:0] a0, b0, a1, b1;
    logic                ovl_next;
    logic [C-1:0]        ps, rs, po, so, ro;
    logic                other_box;
    logic signed [CW-1:0] c1_next, c2_next, h_ext;
    logic [C-1:0]         half_next;

    always_comb
    begin
        a0 = {{2{pa[C-1]}}, pa};
        b0 = {{2{pb[C-1]}}, pb};
        a1 = a0 + $signed({2'b00, sa});
        b1 = b0 + $signed({2'b00, sb});
        ovl_next = (a1 >= b0) && (b1 >= a0);

        // The sphere goes first; the other body is a box or, for two spheres, B.
        if (kind_a == bsc_pkg::KIND_SPHERE)
        begin
            ps = pa;
            rs = ra;
            po = pb;
            so = sb;
            ro = rb;
            other_box = (kind_b == bsc_pkg::KIND_BOX);
        end
        else
        begin
            ps = pb;
            rs = rb;
            po = pa;
            so = sa;
            ro = ra;
            other_box = 1'b1;
        end

        c1_next = $signed({{2{ps[C-1]}}, ps, 1'b0}) + $signed({2'b00, rs, 1'b0});
        h_ext   = other_box ? $signed({3'b000, so}) : $signed({2'b00, ro, 1'b0});
        c2_next = $signed({{2{po[C-1]}}, po, 1'b0}) + h_ext;
        half_next = other_box ? so : '0;
    end

    logic signed [CW-1:0] c1_reg, c2_reg;
    logic [C-1:0]         half1_reg, half2_reg;
    logic                 ovl1_reg, ovl2_reg, ovl3_reg, ovl4_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            half1_reg <= half_next;
            ovl1_reg  <= ovl_next;
        end
    end

    // Stage 2: center difference
    logic signed [DW-1:0] d_next, d_reg;

    assign d_next = $signed({c1_reg[CW-1], c1_reg}) - $signed({c2_reg[CW-1], c2_reg});

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            d_reg     <= d_next;
            half2_reg <= half1_reg;
            ovl2_reg  <= ovl1_reg;
        end
    end

    // Stage 3: clamp to the half extent and take the error
    logic signed [DW-1:0] pos_half, neg_half, cl, e_next, e_reg;

    always_comb
    begin
        pos_half = $signed({4'b0000, half2_reg});
        neg_half = -pos_half;
        if (d_reg < neg_half)
            cl = neg_half;
        else if (d_reg > pos_half)
            cl = pos_half;
        else
            cl = d_reg;
        e_next = cl - d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            e_reg    <= e_next;
            ovl3_reg <= ovl2_reg;
        end
    end

    // Stage 4: square of the error
    logic signed [SQW-1:0] e_wide, prod;
    logic [SQW-1:0]        sq_reg;

    assign e_wide = {{(SQW-DW){e_reg[DW-1]}}, e_reg};
    assign prod   = e_wide * e_wide;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            sq_reg   <= $unsigned(prod);
            ovl4_reg <= ovl3_reg;
        end
    end

    assign sq  = sq_reg;
    assign ovl = ovl4_reg;

endmodule

`default_nettype wire

>>> rtl/bsc_merge.sv
// Merge stage: threshold square, sum of lane squares and final collide decision.
`default_nettype none

module bsc_merge #(
    parameter int COORD_BITS = bsc_pkg::COORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire bsc_pkg::bsc_en_t               en,
    input  wire logic                           kind_a,
    input  wire logic                           kind_b,
    input  wire logic [COORD_BITS-1:0]          ra,
    input  wire logic [COORD_BITS-1:0]          rb,
    input  wire logic [2:0][2*COORD_BITS+7:0]   sq,
    input  wire logic [2:0]                     ovl,
    output logic                                collide
);

    localparam int C    = COORD_BITS;
    localparam int TW   = C + 2;
    localparam int T2W  = 2 * C + 4;
    localparam int SQW  = 2 * C + 8;
    localparam int DSW  = SQW + 2;

    // Stage 1: doubled radius, or doubled radius sum for two spheres
    logic [TW-1:0] thr_next;
    logic          bb_next;

    always_comb
    begin
        bb_next = (kind_a == bsc_pkg::KIND_BOX) && (kind_b == bsc_pkg::KIND_BOX);
        if ((kind_a == bsc_pkg::KIND_SPHERE) && (kind_b == bsc_pkg::KIND_SPHERE))
            thr_next = {1'b0, ra, 1'b0} + {1'b0, rb, 1'b0};
        else if (kind_a == bsc_pkg::KIND_SPHERE)
            thr_next = {1'b0, ra, 1'b0};
        else
            thr_next = {1'b0, rb, 1'b0};
    end

    logic [TW-1:0]  thr1_reg, thr2_reg, thr3_reg;
    logic [T2W-1:0] thr3_wide;
    logic [T2W-1:0] tsq4_reg, tsq5_reg;
    logic           bb1_reg, bb2_reg, bb3_reg, bb4_reg, bb5_reg;
    logic [DSW-1:0] dist_reg;
    logic           ovl5_reg;
    logic           collide_reg;

    assign thr3_wide = {{(T2W-TW){1'b0}}, thr3_reg};

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            thr1_reg <= thr_next;
            bb1_reg  <= bb_next;
        end
        if (en.s2)
        begin
            thr2_reg <= thr1_reg;
            bb2_reg  <= bb1_reg;
        end
        if (en.s3)
        begin
            thr3_reg <= thr2_reg;
            bb3_reg  <= bb2_reg;
        end
        if (en.s4)
        begin
            tsq4_reg <= thr3_wide * thr3_wide;
            bb4_reg  <= bb3_reg;
        end
    end

    // Stage 5: add the three lane squares, AND the overlap bits
    logic [DSW-1:0] dist_next;

    assign dist_next = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            dist_reg <= dist_next;
            tsq5_reg <= tsq4_reg;
            bb5_reg  <= bb4_reg;
            ovl5_reg <= &ovl;
        end
    end

    // Stage 6: output register
    logic collide_next;

    assign collide_next = bb5_reg ? ovl5_reg
                                  : (dist_reg < {{(DSW-T2W){1'b0}}, tsq5_reg});

    always_ff @(posedge clk)
    begin
        if (en.s6)
            collide_reg <= collide_next;
    end

    assign collide = collide_reg;

endmodule

`default_nettype wire
